@@ hw/rtl/chained_free_list_block_allocator_defines.svh @@
// assertion macros for the allocator rtl
`ifndef CHAINED_FREE_LIST_BLOCK_ALLOCATOR_DEFINES_SVH
`define CHAINED_FREE_LIST_BLOCK_ALLOCATOR_DEFINES_SVH

// same-cycle implication, sampled on clk, off while in reset
`define CFBA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while in reset
`define CFBA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/cfba_pkg.sv @@
// shared types and constants of the chained free list block allocator
package cfba_pkg;

  localparam int BLK_W          = 13;
  localparam int STATUS_W       = 2;
  localparam int NUM_BLOCKS_DEF = 8192;
  localparam int SLOTS_DEF      = 9;

  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_ADDR_W-1:0] CFG_ADDR_WP = '0;

  typedef enum logic {
    REQ_ALLOC = 1'b0,
    REQ_FREE  = 1'b1
  } req_t;

  typedef enum logic [STATUS_W-1:0] {
    RSP_DONE       = 2'd0,
    RSP_NO_SPACE   = 2'd1,
    RSP_WP_REFUSED = 2'd2,
    RSP_IGNORED    = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } fsm_t;

  // decision of the node logic for one request
  typedef struct packed {
    logic             wr_en;
    logic             wr_new_node;
    status_t          status;
    logic [BLK_W-1:0] given;
    logic [BLK_W-1:0] head_next;
  } node_op_t;

endpackage

@@ hw/rtl/cfba_req_if.sv @@
// request channel: valid/ready word carrying the request fields
interface cfba_req_if;
  logic                      valid;
  logic                      ready;
  logic                      req_type;
  logic [cfba_pkg::BLK_W-1:0] freed_block;

  modport source (output valid, output req_type, output freed_block, input ready);
  modport sink   (input valid, input req_type, input freed_block, output ready);
endinterface

@@ hw/rtl/cfba_rsp_if.sv @@
// response channel: valid/ready word carrying the result fields
interface cfba_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [cfba_pkg::STATUS_W-1:0] status;
  logic [cfba_pkg::BLK_W-1:0]    allocated_block;
  logic [cfba_pkg::BLK_W-1:0]    head_after;

  modport source (output valid, output status, output allocated_block, output head_after,
                  input ready);
  modport sink   (input valid, input status, input allocated_block, input head_after,
                  output ready);
endinterface

@@ hw/rtl/chained_free_list_block_allocator.sv @@
// chained free list block allocator: node row memory, sequencer and apb register
// the request and head row are registered at accept, the result word in exec once the output register is free
// requests are taken one at a time: a new one only in idle, after the last result word is loaded
//   (row read at accept, modified row written back when the result word is loaded)
// reset: synchronous active-low rst_n clears the sequencer, the output valid, write_protect and the head
//   (chain empty); the node memory is not cleared and needs no clearing pass
module chained_free_list_block_allocator #(
  parameter int NUM_BLOCKS     = cfba_pkg::NUM_BLOCKS_DEF,
  parameter int SLOTS_PER_NODE = cfba_pkg::SLOTS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  cfba_req_if.sink                          in_req,
  cfba_rsp_if.source                        out_rsp,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [cfba_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [cfba_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [cfba_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                              pready
);

`include "chained_free_list_block_allocator_defines.svh"

  localparam int BW    = cfba_pkg::BLK_W;
  localparam int ROW_W = (SLOTS_PER_NODE + 1) * BW;
  localparam int AW    = $clog2(NUM_BLOCKS);

  // one row per block: link word then the slot words
  logic [ROW_W-1:0] node_mem [NUM_BLOCKS];

  cfba_pkg::fsm_t      state_r, state_nxt;
  logic                wp_r, wp_nxt;
  logic [BW-1:0]       head_r, head_nxt;
  logic                out_valid_r, out_valid_nxt;

  // payload registers, no reset
  logic [ROW_W-1:0]    rdata_r;
  logic                req_type_r;
  logic [BW-1:0]       blk_r;
  logic [cfba_pkg::STATUS_W-1:0] out_status_r;
  logic [BW-1:0]       out_given_r;
  logic [BW-1:0]       out_head_r;

  logic                accept;
  logic                rsp_load;
  logic                mem_we;
  logic [AW-1:0]       wr_addr;
  logic [ROW_W-1:0]    wr_row;
  logic                cfg_wr;
  cfba_pkg::node_op_t  op;

  // handshakes
  assign in_req.ready = (state_r == cfba_pkg::S_IDLE);
  assign accept       = in_req.valid && in_req.ready;
  // finish the item once the output register is free or being drained
  assign rsp_load     = (state_r == cfba_pkg::S_EXEC) && (!out_valid_r || out_rsp.ready);
  assign mem_we       = rsp_load && op.wr_en;
  assign wr_addr      = op.wr_new_node ? AW'(blk_r) : AW'(head_r);

  assign out_rsp.valid           = out_valid_r;
  assign out_rsp.status          = out_status_r;
  assign out_rsp.allocated_block = out_given_r;
  assign out_rsp.head_after      = out_head_r;

  // apb register: write_protect at the first word, zero wait states
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr == cfba_pkg::CFG_ADDR_WP);
  assign prdata = (paddr == cfba_pkg::CFG_ADDR_WP) ? cfba_pkg::CFG_DATA_W'(wp_r) : '0;

  cfba_node_logic #(
    .NUM_BLOCKS     (NUM_BLOCKS),
    .SLOTS_PER_NODE (SLOTS_PER_NODE)
  ) u_node_logic (
    .req_type      (req_type_r),
    .blk           (blk_r),
    .write_protect (wp_r),
    .head          (head_r),
    .row           (rdata_r),
    .wr_row        (wr_row),
    .op            (op)
  );

  // sequencer: idle takes a word and reads the head row, exec decides and writes back
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      cfba_pkg::S_IDLE: begin
        if (accept) begin
          state_nxt = cfba_pkg::S_EXEC;
        end
      end
      cfba_pkg::S_EXEC: begin
        if (rsp_load) begin
          state_nxt = cfba_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = cfba_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    wp_nxt        = cfg_wr ? pwdata[0] : wp_r;
    head_nxt      = rsp_load ? op.head_next : head_r;
    out_valid_nxt = out_valid_r;
    if (rsp_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_rsp.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cfba_pkg::S_IDLE;
      wp_r        <= 1'b0;
      head_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wp_r        <= wp_nxt;
      head_r      <= head_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // capture the request and read the head row in the same edge;
  // the previous write back has always landed by then, so no forwarding
  always_ff @(posedge clk) begin
    if (accept) begin
      req_type_r <= in_req.req_type;
      blk_r      <= in_req.freed_block;
      rdata_r    <= node_mem[AW'(head_r)];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      node_mem[wr_addr] <= wr_row;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      out_status_r <= op.status;
      out_given_r  <= op.given;
      out_head_r   <= op.head_next;
    end
  end

  `CFBA_ASSERT_NEXT(a_accept_to_exec, accept, state_r == cfba_pkg::S_EXEC, "accepted word did not start exec")
  `CFBA_ASSERT_NEXT(a_write_has_result, mem_we, out_valid_r, "row write back without a result word")
  `CFBA_ASSERT_NOW(a_head_in_range, 1'b1, 32'(head_r) < NUM_BLOCKS, "head block out of range")
  `CFBA_ASSERT_NOW(a_alloc_nonzero, rsp_load && (op.status == cfba_pkg::RSP_DONE) && (req_type_r == cfba_pkg::REQ_ALLOC), op.given != '0, "successful allocate handed out block zero")

endmodule

@@ hw/rtl/cfba_node_logic.sv @@
// decides one request from the head node row and builds the row to write back
module cfba_node_logic #(
  parameter int NUM_BLOCKS     = cfba_pkg::NUM_BLOCKS_DEF,
  parameter int SLOTS_PER_NODE = cfba_pkg::SLOTS_DEF
) (
  input  logic                                             req_type,
  input  logic [cfba_pkg::BLK_W-1:0]                       blk,
  input  logic                                             write_protect,
  input  logic [cfba_pkg::BLK_W-1:0]                       head,
  input  logic [(SLOTS_PER_NODE+1)*cfba_pkg::BLK_W-1:0]    row,
  output logic [(SLOTS_PER_NODE+1)*cfba_pkg::BLK_W-1:0]    wr_row,
  output cfba_pkg::node_op_t                               op
);

  localparam int BW = cfba_pkg::BLK_W;
  localparam int IW = $clog2(SLOTS_PER_NODE + 1);

  logic [IW-1:0] last_idx;
  logic [IW-1:0] first_idx;
  logic          have_last;
  logic          have_free;
  logic [BW-1:0] slot_val;
  logic [BW-1:0] link;
  logic [BW-1:0] link_ok;
  logic          blk_ok;
  logic          clr_slot;
  logic          put_slot;
  logic          new_node;

  // last occupied slot and first empty slot, word 0 is the link
  always_comb begin
    last_idx  = '0;
    have_last = 1'b0;
    first_idx = '0;
    have_free = 1'b0;
    slot_val  = '0;
    for (int i = 1; i <= SLOTS_PER_NODE; i++) begin
      if (row[i*BW +: BW] != '0) begin
        last_idx  = IW'(i);
        have_last = 1'b1;
      end
    end
    for (int i = SLOTS_PER_NODE; i >= 1; i--) begin
      if (row[i*BW +: BW] == '0) begin
        first_idx = IW'(i);
        have_free = 1'b1;
      end
    end
    for (int i = 1; i <= SLOTS_PER_NODE; i++) begin
      if (IW'(i) == last_idx) begin
        slot_val = row[i*BW +: BW];
      end
    end
  end

  assign link    = row[BW-1:0];
  assign link_ok = (32'(link) < NUM_BLOCKS) ? link : '0;
  assign blk_ok  = (blk != '0) && (32'(blk) < NUM_BLOCKS);

  always_comb begin
    op           = '0;
    op.status    = cfba_pkg::RSP_DONE;
    op.head_next = head;
    clr_slot     = 1'b0;
    put_slot     = 1'b0;
    new_node     = 1'b0;
    if (req_type == cfba_pkg::REQ_ALLOC) begin
      if (write_protect) begin
        op.status = cfba_pkg::RSP_WP_REFUSED;
      end else if (head == '0) begin
        op.status = cfba_pkg::RSP_NO_SPACE;
      end else if (have_last) begin
        op.given = slot_val;
        op.wr_en = 1'b1;
        clr_slot = 1'b1;
      end else begin
        // node is empty: hand out the node itself and follow the link
        op.given     = head;
        op.head_next = link_ok;
      end
    end else begin
      if (write_protect || !blk_ok) begin
        op.status = cfba_pkg::RSP_IGNORED;
      end else if ((head != '0) && have_free) begin
        op.wr_en = 1'b1;
        put_slot = 1'b1;
      end else begin
        // freed block starts a new head node linked to the old head
        op.wr_en       = 1'b1;
        op.wr_new_node = 1'b1;
        op.head_next   = blk;
        new_node       = 1'b1;
      end
    end
  end

  always_comb begin
    wr_row = row;
    for (int i = 0; i <= SLOTS_PER_NODE; i++) begin
      if (i == 0) begin
        if (new_node) begin
          wr_row[i*BW +: BW] = head;
        end
      end else if (new_node) begin
        wr_row[i*BW +: BW] = '0;
      end else if (clr_slot && (IW'(i) == last_idx)) begin
        wr_row[i*BW +: BW] = '0;
      end else if (put_slot && (IW'(i) == first_idx)) begin
        wr_row[i*BW +: BW] = blk;
      end
    end
  end

endmodule
